// ===== rtl/core/half_step_stepper_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the half-step sequencer
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HALF_STEP_STEPPER_SEQUENCER_MACROS_SVH
`define HALF_STEP_STEPPER_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent holds -> consequent holds in the same cycle
`define HSSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// antecedent holds -> consequent holds in the next cycle
`define HSSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`else

`define HSSS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HSSS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/hsss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-step sequencer package
// Word types, command and motion codes and the half-step coil table.
// ----------------------------------------------------------------------------
package hsss_pkg;

   // default tick rate (microsecond timestamps)
   localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

   localparam int unsigned RATE_W     = 16;
   localparam int unsigned NOW_W      = 63;
   localparam int unsigned DUE_W      = 64;
   localparam int unsigned INTERVAL_W = 20;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;
   localparam logic [RATE_W-1:0]     MAX_RATE_RST = 16'd1000;

   // commands
   localparam logic [1:0] CMD_SERVICE = 2'd0;
   localparam logic [1:0] CMD_MOTION  = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   // motion / direction codes
   localparam logic [1:0] MOTION_STOP = 2'd0;
   localparam logic [1:0] MOTION_CW   = 2'd1;
   localparam logic [1:0] MOTION_CCW  = 2'd2;

   // configuration register indexes
   localparam logic CSR_INVERT   = 1'b0;
   localparam logic CSR_MAX_RATE = 1'b1;

   typedef struct packed {
      logic [1:0]        command;
      logic [1:0]        direction;
      logic [RATE_W-1:0] rate;
      logic [NOW_W-1:0]  now;
   } req_word_type;

   typedef struct packed {
      logic               stepped;
      logic [3:0]         coils;
      logic signed [31:0] position;
   } rsp_word_type;

   // half-step coil pattern for each phase
   function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
      logic [3:0] pattern;
      unique case (phase)
         3'd0: pattern = 4'h1;
         3'd1: pattern = 4'h3;
         3'd2: pattern = 4'h2;
         3'd3: pattern = 4'h6;
         3'd4: pattern = 4'h4;
         3'd5: pattern = 4'hC;
         3'd6: pattern = 4'h8;
         3'd7: pattern = 4'h9;
         default: pattern = 4'h0;
      endcase
      return pattern;
   endfunction

endpackage

// ===== rtl/core/half_step_stepper_sequencer.sv =====
`timescale 1ns / 1ps
// Half-step sequencer for a four-coil unipolar stepper. One word is taken at a
// time and gives exactly one response word. A service tick passes through
// ST_SERVICE (and ST_FIX when a step is made: the due time is moved on, then
// re-anchored if late) to ST_RESP; a release, unknown command or stop goes
// straight to ST_RESP, and a start runs ST_DIV first: the step
// interval comes from a restoring divider that yields one quotient bit a cycle.
// The response register lets the next word start while a response is waiting.
// ----------------------------------------------------------------------------
// Half-step stepper sequencer
// Command decode, iterative interval divider, step timing and coil drive.
// ----------------------------------------------------------------------------
`include "half_step_stepper_sequencer_macros.svh"

module half_step_stepper_sequencer
   import hsss_pkg::*;
#(
   parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   // configuration
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned TICK_W = $clog2(TICKS_PER_SECOND + 1);
   localparam int unsigned CNT_W  = $clog2(TICK_W + 1);
   localparam int unsigned QX_W   = (TICK_W > INTERVAL_W) ? TICK_W : INTERVAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SERVICE,
      ST_FIX,
      ST_RESP
   } state_type;

   state_type             state_ff;

   // configuration
   logic                  invert_ff;
   logic [RATE_W-1:0]     max_rate_ff;

   // motion state
   logic [1:0]            motion_ff;
   logic [2:0]            phase_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [DUE_W-1:0]      due_ff;
   logic [POS_W-1:0]      step_count_ff;
   logic [3:0]            coil_ff;

   // working registers
   logic [NOW_W-1:0]      now_ff;
   logic                  stepped_ff;
   logic [1:0]            dir_ff;
   logic [RATE_W-1:0]     divisor_ff;
   logic [RATE_W-1:0]     rem_ff;
   logic [TICK_W-1:0]     num_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic                  rsp_valid_ff;
   rsp_word_type          rsp_data_ff;

   // request decode
   logic                  req_fire;
   logic                  start_stop;
   logic [RATE_W-1:0]     limit;
   logic [RATE_W-1:0]     rate_clamped;
   logic [1:0]            dir_in;

   // divider step
   logic [RATE_W:0]       trial;
   logic [RATE_W+1:0]     diff;
   logic                  ge;
   logic [RATE_W-1:0]     rem_in;
   logic [TICK_W-1:0]     num_in;
   logic [QX_W-1:0]       quo_ext;
   logic [INTERVAL_W-1:0] interval_in;

   // step timing
   logic [DUE_W-1:0]      now_ext;
   logic                  svc_step;
   logic                  rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign now_ext   = {1'b0, now_ff};

   // set-motion decode: stop test, clamp, direction swap
   always_comb begin
      start_stop   = !((req_data.direction == MOTION_CW) ||
                       (req_data.direction == MOTION_CCW)) ||
                     (req_data.rate == '0);
      limit        = (max_rate_ff == '0) ? RATE_W'(1) : max_rate_ff;
      rate_clamped = (req_data.rate > limit) ? limit : req_data.rate;
      if (invert_ff) begin
         dir_in = (req_data.direction == MOTION_CW) ? MOTION_CCW : MOTION_CW;
      end else begin
         dir_in = req_data.direction;
      end
   end

   // restoring divider: one quotient bit per cycle
   always_comb begin
      trial       = {rem_ff, num_ff[TICK_W-1]};
      diff        = {1'b0, trial} - {2'b00, divisor_ff};
      ge          = !diff[RATE_W+1];
      rem_in      = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      num_in      = {num_ff[TICK_W-2:0], ge};
      quo_ext     = QX_W'(num_in);
      interval_in = (quo_ext > QX_W'(INTERVAL_MAX)) ? INTERVAL_MAX
                                                    : quo_ext[INTERVAL_W-1:0];
   end

   // step due test
   assign svc_step = (motion_ff != MOTION_STOP) && (now_ext >= due_ff);

   // sequencer, motion state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         invert_ff     <= 1'b0;
         max_rate_ff   <= MAX_RATE_RST;
         motion_ff     <= MOTION_STOP;
         phase_ff      <= '0;
         interval_ff   <= '0;
         due_ff        <= '0;
         step_count_ff <= '0;
         coil_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // configuration writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_INVERT:   invert_ff   <= csr_wdata[0];
               CSR_MAX_RATE: max_rate_ff <= csr_wdata[RATE_W-1:0];
               default:      ;
            endcase
         end

         // response taken; in ST_RESP the load below decides
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  now_ff     <= req_data.now;
                  stepped_ff <= 1'b0;
                  unique case (req_data.command)
                     CMD_SERVICE: state_ff <= ST_SERVICE;
                     CMD_MOTION: begin
                        if (start_stop) begin
                           motion_ff <= MOTION_STOP;
                           coil_ff   <= '0;
                           state_ff  <= ST_RESP;
                        end else begin
                           dir_ff     <= dir_in;
                           divisor_ff <= rate_clamped;
                           rem_ff     <= '0;
                           num_ff     <= TICK_W'(TICKS_PER_SECOND);
                           cnt_ff     <= CNT_W'(TICK_W);
                           state_ff   <= ST_DIV;
                        end
                     end
                     CMD_RELEASE: begin
                        coil_ff  <= '0;
                        state_ff <= ST_RESP;
                     end
                     default: state_ff <= ST_RESP;
                  endcase
               end
            end

            ST_DIV: begin
               rem_ff <= rem_in;
               num_ff <= num_in;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  interval_ff <= interval_in;
                  due_ff      <= now_ext;
                  motion_ff   <= dir_ff;
                  state_ff    <= ST_RESP;
               end
            end

            ST_SERVICE: begin
               if (svc_step) begin
                  stepped_ff <= 1'b1;
                  if (motion_ff == MOTION_CW) begin
                     phase_ff      <= phase_ff + 3'd1;
                     coil_ff       <= half_step_coils(phase_ff + 3'd1);
                     step_count_ff <= invert_ff ? step_count_ff - POS_W'(1)
                                                : step_count_ff + POS_W'(1);
                  end else begin
                     phase_ff      <= phase_ff - 3'd1;
                     coil_ff       <= half_step_coils(phase_ff - 3'd1);
                     step_count_ff <= invert_ff ? step_count_ff + POS_W'(1)
                                                : step_count_ff - POS_W'(1);
                  end
                  due_ff   <= due_ff + DUE_W'(interval_ff);
                  state_ff <= ST_FIX;
               end else begin
                  state_ff <= ST_RESP;
               end
            end

            // re-anchor when the block has fallen behind
            ST_FIX: begin
               if (due_ff < now_ext) begin
                  due_ff <= now_ext + DUE_W'(interval_ff);
               end
               state_ff <= ST_RESP;
            end

            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.stepped  <= stepped_ff;
                  rsp_data_ff.coils    <= coil_ff;
                  rsp_data_ff.position <= $signed(step_count_ff);
                  state_ff             <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   `HSSS_ASSERT_IMPLY(a_div_rem_below_divisor, clock, reset,
      state_ff == ST_DIV, rem_ff < divisor_ff)
   `HSSS_ASSERT_NEXT(a_step_moves_one_phase, clock, reset,
      state_ff == ST_SERVICE && svc_step,
      phase_ff == 3'($past(phase_ff) + 3'd1) || phase_ff == 3'($past(phase_ff) - 3'd1))
   `HSSS_ASSERT_NEXT(a_due_not_behind_after_fix, clock, reset,
      state_ff == ST_FIX, due_ff >= now_ext)
   `HSSS_ASSERT_IMPLY(a_step_drives_coils, clock, reset,
      rsp_valid_ff && rsp_data_ff.stepped, rsp_data_ff.coils != 4'h0)

endmodule

// ===== sim/half_step_stepper_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-step stepper sequencer testbench
// Request words come from a pending queue through a clocked driver, and every
// accepted word is run through a cycle-free model of the sequencer. Each
// response word is checked field by field against the oldest predicted word.
// A directed opening covers stops, clamping, late and early service ticks,
// release and the time extremes. Six phases of random motion traffic follow,
// each with its own register setting; phase pairs share both idle patterns.
// ----------------------------------------------------------------------------

module half_step_stepper_sequencer_tb;
   import hsss_pkg::*;

   localparam int unsigned PHASE_WORDS   = 225;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PRINT_LIMIT   = 40;

   // codes outside the defined sets
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [1:0] DIR_UNKNOWN = 2'd3;

   localparam logic [NOW_W-1:0] NOW_MAX = '1;

   // half-step coil patterns, phase 0 in the low nibble
   localparam logic [31:0] COIL_SEQ = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

   // register setting per random phase (phase 0 in the low bits)
   localparam logic [5:0]  INVERT_PLAN = 6'b010101;
   localparam logic [95:0] LIMIT_PLAN  = {16'd300, 16'd1000, 16'd65535,
                                          16'd1, 16'd0, 16'd65535};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_INVERT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   half_step_stepper_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // stimulus and expectation stores
   req_word_type pending_words [$];
   rsp_word_type expected_rsp [$];
   logic         req_taken = 1'b0;
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  error_count = 0;
   int unsigned  rsp_count = 0;

   // model copy of registers and sequencer state
   logic                  invert_q = 1'b0;
   logic [RATE_W-1:0]     max_rate_q = MAX_RATE_RST;
   logic [1:0]            motion_q = MOTION_STOP;
   logic [2:0]            phase_q = '0;
   logic [INTERVAL_W-1:0] interval_q = '0;
   logic [DUE_W-1:0]      due_q = '0;
   logic [POS_W-1:0]      position_q = '0;
   logic [3:0]            coils_q = '0;

   // generator view of time and step pace
   logic [NOW_W-1:0] now_cursor = '0;
   longint unsigned  pace_us = 1000;
   logic [RATE_W-1:0] gen_limit = MAX_RATE_RST;

   initial begin
      forever #5 clock = ~clock;
   end

   // sequencer model: applies one request word, returns the response word
   function automatic rsp_word_type advance_sequencer(input req_word_type w);
      rsp_word_type    r;
      logic [1:0]      dir;
      logic [RATE_W-1:0] lim;
      logic [RATE_W-1:0] rt;
      logic [DUE_W-1:0]  now64;
      longint unsigned quo;
      r = '0;
      dir = w.direction;
      now64 = {1'b0, w.now};
      case (w.command)
         CMD_SERVICE: begin
            if (motion_q != MOTION_STOP && now64 >= due_q) begin
               r.stepped = 1'b1;
               if (motion_q == MOTION_CW) begin
                  phase_q = phase_q + 3'd1;
                  position_q = position_q + (invert_q ? 32'hFFFF_FFFF : 32'd1);
               end else begin
                  phase_q = phase_q - 3'd1;
                  position_q = position_q + (invert_q ? 32'd1 : 32'hFFFF_FFFF);
               end
               coils_q = COIL_SEQ[phase_q*4 +: 4];
               due_q = due_q + DUE_W'(interval_q);
               // fallen behind: re-anchor on now
               if (due_q < now64) due_q = now64 + DUE_W'(interval_q);
            end
         end
         CMD_MOTION: begin
            if ((dir != MOTION_CW && dir != MOTION_CCW) || w.rate == '0) begin
               motion_q = MOTION_STOP;
               coils_q = '0;
            end else begin
               lim = (max_rate_q == '0) ? RATE_W'(1) : max_rate_q;
               rt = (w.rate > lim) ? lim : w.rate;
               if (invert_q) dir = (dir == MOTION_CW) ? MOTION_CCW : MOTION_CW;
               quo = 64'(TICKS_PER_SECOND_DEF) / 64'(rt);
               interval_q = (quo > 64'(INTERVAL_MAX)) ? INTERVAL_MAX : quo[INTERVAL_W-1:0];
               due_q = now64;
               motion_q = dir;
            end
         end
         CMD_RELEASE: coils_q = '0;
         default: ;
      endcase
      r.coils = coils_q;
      r.position = position_q;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (error_count < PRINT_LIMIT)
         $display("%0t ns  word %0d: %s got %0h want %0h", $time, rsp_count, what, got, want);
      error_count++;
   endtask

   task automatic check_rsp(input rsp_word_type got);
      rsp_word_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch("response with nothing outstanding", 64'(got), 0);
      end else begin
         want = expected_rsp.pop_front();
         if (got.stepped !== want.stepped)
            report_mismatch("stepped", 64'(got.stepped), 64'(want.stepped));
         if (got.coils !== want.coils)
            report_mismatch("coils", 64'(got.coils), 64'(want.coils));
         if (got.position !== want.position)
            report_mismatch("position", 64'(got.position), 64'(want.position));
      end
      rsp_count++;
   endtask

   // monitor: register writes, accepted requests and response words
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_INVERT) invert_q = csr_wdata[0];
            else max_rate_q = csr_wdata;
         end
         if (req_valid && req_ready) expected_rsp.push_back(advance_sequencer(req_data));
         if (rsp_valid && rsp_ready) check_rsp(rsp_data);
      end
   end

   // driver: holds a word until taken, then offers the next one or idles
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // still waiting for acceptance
      end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_data <= pending_words.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic push_word(input logic [1:0] cmd, input logic [1:0] dir,
                            input logic [RATE_W-1:0] rate, input logic [NOW_W-1:0] now);
      req_word_type w;
      w.command = cmd;
      w.direction = dir;
      w.rate = rate;
      w.now = now;
      pending_words.push_back(w);
   endtask

   // random motion traffic: mostly service ticks around the step pace, with
   // starts, stops, releases, unknown commands and time jumps
   task automatic queue_traffic(input int unsigned count);
      req_word_type    w;
      int unsigned     pick;
      longint unsigned lim;
      longint unsigned eff;
      longint unsigned back;
      for (int unsigned i = 0; i < count; i++) begin
         w.command = CMD_SERVICE;
         w.direction = 2'($urandom_range(0, 3));
         w.rate = RATE_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            w.command = CMD_MOTION;
            w.direction = $urandom_range(0, 1) ? MOTION_CW : MOTION_CCW;
            case ($urandom_range(0, 3))
               0: w.rate = RATE_W'($urandom_range(1, 50));
               1: w.rate = RATE_W'($urandom_range(1, 65535));
               2: w.rate = (gen_limit == '0) ? RATE_W'(1) : gen_limit;
               default: w.rate = RATE_W'($urandom_range(200, 2000));
            endcase
            lim = (gen_limit == '0) ? 1 : gen_limit;
            eff = (w.rate > lim) ? lim : w.rate;
            pace_us = 64'(TICKS_PER_SECOND_DEF) / eff;
         end else if (pick < 13) begin
            // stop by direction, unknown direction or zero rate
            w.command = CMD_MOTION;
            case ($urandom_range(0, 2))
               0: w.direction = MOTION_STOP;
               1: w.direction = DIR_UNKNOWN;
               default: w.rate = '0;
            endcase
         end else if (pick < 18) begin
            w.command = CMD_RELEASE;
         end else if (pick < 20) begin
            w.command = CMD_UNKNOWN;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               now_cursor = now_cursor + NOW_W'($urandom_range(0, 32'(pace_us)));
            end else if (pick < 80) begin
               now_cursor = now_cursor + NOW_W'(pace_us + $urandom_range(0, 1));
            end else if (pick < 90) begin
               now_cursor = now_cursor + NOW_W'(pace_us * $urandom_range(2, 5));
            end else if (pick < 95) begin
               // same timestamp again
            end else if (pick < 98) begin
               back = $urandom_range(0, 32'(pace_us));
               if (64'(now_cursor) > back) now_cursor = now_cursor - NOW_W'(back);
            end else begin
               now_cursor = {31'($urandom), 32'($urandom)};
            end
         end
         w.now = now_cursor;
         pending_words.push_back(w);
      end
   endtask

   // sender pause: nothing waiting, nothing in flight, every response back
   task automatic wait_drained;
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // main sequence
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening at reset settings
      send_idle_pct = 13;
      recv_idle_pct = 77;
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, '0);             // stopped, no step
      push_word(CMD_UNKNOWN, DIR_UNKNOWN, 16'hFFFF, NOW_MAX);     // ignored command
      push_word(CMD_RELEASE, MOTION_CW, 16'd5, 63'd10);
      push_word(CMD_MOTION, MOTION_CW, 16'd0, 63'd20);            // zero rate stops
      push_word(CMD_MOTION, DIR_UNKNOWN, 16'd500, 63'd30);        // unknown direction
      push_word(CMD_MOTION, MOTION_CW, 16'hFFFF, 63'd100);        // clamped to 1000
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd100);        // first step at once
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd1099);       // one tick early
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd1100);       // exactly due
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd9000);       // late, re-anchor
      push_word(CMD_RELEASE, MOTION_STOP, 16'd0, 63'd9500);
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd10000);      // coils back on
      push_word(CMD_MOTION, MOTION_CCW, 16'd1, 63'd20000);        // slowest rate
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd20000);
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd1019999);
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd1020000);
      push_word(CMD_MOTION, MOTION_STOP, 16'd100, 63'd1030000);   // stop keeps phase
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, 63'd5000000);
      push_word(CMD_MOTION, MOTION_CW, 16'd1000, NOW_MAX - 63'd500);
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, NOW_MAX);        // top of time
      push_word(CMD_SERVICE, MOTION_STOP, 16'd0, NOW_MAX);        // not due again
      push_word(CMD_MOTION, MOTION_CCW, 16'd1000, '0);
      push_word(CMD_SERVICE, MOTION_CCW, 16'hFFFF, '0);
      wait_drained();

      now_cursor = 63'd1_000_000_000;
      for (int unsigned p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle_pct = 13;
            recv_idle_pct = 77;
         end else if (p < 4) begin
            send_idle_pct = 77;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         gen_limit = LIMIT_PLAN[p*16 +: 16];
         csr_write(CSR_INVERT, CSR_DATA_W'(INVERT_PLAN[p]));
         csr_write(CSR_MAX_RATE, gen_limit);
         queue_traffic(PHASE_WORDS);
         wait_drained();
      end

      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("half_step_stepper_sequencer_tb: done, clean");
      end else begin
         $display("half_step_stepper_sequencer_tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("half_step_stepper_sequencer_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hsss_pkg.sv
rtl/core/half_step_stepper_sequencer.sv
sim/half_step_stepper_sequencer_tb.sv
